// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared shorthands for clocked assertions on clk_i with reset rst_ni
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BSM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bsm assertion failed");

// next-cycle implication
`define BSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bsm assertion failed");

`endif

// ===== rtl/core/bsm_pkg.sv =====
// ---------------------------------------------------------------------------
// bsm_pkg
// shared widths, codes and types of the bouncing sprite motion core
// ---------------------------------------------------------------------------
package bsm_pkg;

  localparam int STEP_W     = 10;
  localparam int SKEW_W     = 3;
  localparam int SCREEN_W   = 12;
  localparam int TICK_W     = 7;
  localparam int SEC_W      = 4;
  localparam int SIZE_W     = 12;
  localparam int PCT_W      = 6;
  localparam int KIND_W     = 2;
  localparam int OUT_W      = 14;
  localparam int PHASE_W    = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int COORD_BITS_DEF  = 14;
  localparam int INITIAL_TOP_DEF = 100;

  localparam logic [TICK_W-1:0]  TICK_MIN  = 7'd10;
  localparam logic [PCT_W-1:0]   PCT_MAX   = 6'd41;
  localparam logic [PHASE_W-1:0] MS_PER_S  = 15'd1000;
  localparam logic [PHASE_W-1:0] CENTER_MS = 15'd101;

  // floor(p / 100) as (p * RECIP_M) >> RECIP_K, exact for p below 2^18
  localparam int PROD_W  = SCREEN_W + PCT_W;
  localparam int RECIP_W = 19;
  localparam int RECIP_K = 25;
  localparam logic [RECIP_W-1:0] RECIP_M = 19'd335545;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STEP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CENTER = 2'd2;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PIXELS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKEW_DIVISOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOM_HOP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_MS        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_SECONDS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_SECONDS  = 3'd7;

  // register reset values
  localparam logic [STEP_W-1:0]   RST_STEP_PIXELS    = 10'd42;
  localparam logic [SKEW_W-1:0]   RST_SKEW_DIVISOR   = 3'd4;
  localparam logic [SCREEN_W-1:0] RST_SCREEN_WIDTH   = 12'd1024;
  localparam logic [SCREEN_W-1:0] RST_SCREEN_HEIGHT  = 12'd768;
  localparam logic                RST_RANDOM_HOP     = 1'b1;
  localparam logic [TICK_W-1:0]   RST_TICK_MS        = 7'd10;
  localparam logic [SEC_W-1:0]    RST_BOUNCE_SECONDS = 4'd3;
  localparam logic [SEC_W-1:0]    RST_PAUSE_SECONDS  = 4'd3;

  // datapath micro-operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_MOVE,
    OP_RECIP,
    OP_CLAMP,
    OP_CENTER,
    OP_WRAP,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic en;
    logic ready;
  } bsm_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_blocked;
    logic pause;
    logic div_more;
  } bsm_status_t;

  typedef struct packed {
    logic [STEP_W-1:0]   step_pixels;
    logic [SKEW_W-1:0]   skew_divisor;
    logic [SCREEN_W-1:0] screen_width;
    logic [SCREEN_W-1:0] screen_height;
    logic                random_hop;
    logic [TICK_W-1:0]   tick_ms;
    logic [SEC_W-1:0]    bounce_seconds;
    logic [SEC_W-1:0]    pause_seconds;
  } bsm_cfg_t;

endpackage

// ===== rtl/core/bsm_sequencer.sv =====
// ---------------------------------------------------------------------------
// bsm_sequencer
// step counter and control store; one control word per step with a jump
// ---------------------------------------------------------------------------
module bsm_sequencer import bsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bsm_status_t status_i,
  output bsm_ctrl_t   ctrl_o
);

  localparam int UPC_W = 4;

  localparam logic [UPC_W-1:0] S_FETCH  = 4'd0;
  localparam logic [UPC_W-1:0] S_CHECK  = 4'd1;
  localparam logic [UPC_W-1:0] S_DIV    = 4'd2;
  localparam logic [UPC_W-1:0] S_MOVE   = 4'd3;
  localparam logic [UPC_W-1:0] S_RECIP  = 4'd4;
  localparam logic [UPC_W-1:0] S_CLAMP  = 4'd5;
  localparam logic [UPC_W-1:0] S_EMIT   = 4'd6;
  localparam logic [UPC_W-1:0] S_RET    = 4'd7;
  localparam logic [UPC_W-1:0] S_CENTER = 4'd8;
  localparam logic [UPC_W-1:0] S_WRAP   = 4'd9;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_OUT_BLOCKED,
    C_PAUSE,
    C_DIV_MORE
  } cond_e;

  // hold: the operation waits while the jump is taken
  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic             hold;
    logic [UPC_W-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      S_FETCH:  w = '{op: OP_LOAD,   cond: C_NO_INPUT,    hold: 1'b1, target: S_FETCH};
      S_CHECK:  w = '{op: OP_NOP,    cond: C_PAUSE,       hold: 1'b0, target: S_CENTER};
      S_DIV:    w = '{op: OP_DIV,    cond: C_DIV_MORE,    hold: 1'b0, target: S_DIV};
      S_MOVE:   w = '{op: OP_MOVE,   cond: C_NEVER,       hold: 1'b0, target: S_FETCH};
      S_RECIP:  w = '{op: OP_RECIP,  cond: C_NEVER,       hold: 1'b0, target: S_FETCH};
      S_CLAMP:  w = '{op: OP_CLAMP,  cond: C_NEVER,       hold: 1'b0, target: S_FETCH};
      S_EMIT:   w = '{op: OP_EMIT,   cond: C_OUT_BLOCKED, hold: 1'b1, target: S_EMIT};
      S_RET:    w = '{op: OP_NOP,    cond: C_ALWAYS,      hold: 1'b0, target: S_FETCH};
      S_CENTER: w = '{op: OP_CENTER, cond: C_NEVER,       hold: 1'b0, target: S_FETCH};
      S_WRAP:   w = '{op: OP_WRAP,   cond: C_ALWAYS,      hold: 1'b0, target: S_EMIT};
      default:  w = '{op: OP_NOP,    cond: C_ALWAYS,      hold: 1'b0, target: S_FETCH};
    endcase
    return w;
  endfunction

  logic [UPC_W-1:0] upc_q, upc_d;
  ucode_t           word;
  logic             taken;

  assign word = ucode_rom(upc_q);

  always_comb begin
    unique case (word.cond)
      C_NEVER:       taken = 1'b0;
      C_ALWAYS:      taken = 1'b1;
      C_NO_INPUT:    taken = !status_i.in_valid;
      C_OUT_BLOCKED: taken = status_i.out_blocked;
      C_PAUSE:       taken = status_i.pause;
      C_DIV_MORE:    taken = status_i.div_more;
      default:       taken = 1'b0;
    endcase
  end

  assign upc_d = taken ? word.target : upc_q + UPC_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_RET;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o.op    = word.op;
  assign ctrl_o.en    = !(word.hold && taken);
  assign ctrl_o.ready = (upc_q == S_FETCH);

endmodule

// ===== rtl/core/bsm_serial_div.sv =====
// ---------------------------------------------------------------------------
// bsm_serial_div
// restoring divider, one quotient bit per step
// ---------------------------------------------------------------------------
module bsm_serial_div import bsm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              step_i,
  input  logic [STEP_W-1:0] dividend_i,
  input  logic [SKEW_W-1:0] divisor_i,
  output logic [STEP_W-1:0] quotient_o,
  output logic              more_o
);

  localparam int CNT_W = $clog2(STEP_W);

  logic [SKEW_W-1:0] rem_q;
  logic [STEP_W-1:0] quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SKEW_W:0]   trial;
  logic              fits;

  assign trial = {rem_q, quo_q[STEP_W-1]};
  assign fits  = (trial >= {1'b0, divisor_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (step_i) begin
      if (fits) begin
        rem_q <= SKEW_W'(trial - {1'b0, divisor_i});
      end else begin
        rem_q <= trial[SKEW_W-1:0];
      end
      quo_q <= {quo_q[STEP_W-2:0], fits};
    end
  end

  assign quotient_o = quo_q;
  assign more_o     = (cnt_q != CNT_W'(STEP_W - 1));

endmodule

// ===== rtl/core/bsm_datapath.sv =====
// ---------------------------------------------------------------------------
// bsm_datapath
// motion state, clamp and bounce logic, hop height, result and output words
// ---------------------------------------------------------------------------
module bsm_datapath import bsm_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int INITIAL_TOP = INITIAL_TOP_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bsm_cfg_t                 cfg_i,
  input  bsm_ctrl_t                ctrl_i,
  input  logic                     in_valid_i,
  input  logic [SIZE_W-1:0]        rect_width_i,
  input  logic [SIZE_W-1:0]        rect_height_i,
  input  logic [PCT_W-1:0]         random_percent_i,
  input  logic                     out_stall_i,
  output bsm_status_t              status_o,
  output logic                     out_valid_o,
  output logic [KIND_W-1:0]        move_kind_o,
  output logic signed [OUT_W-1:0]  pos_x_o,
  output logic signed [OUT_W-1:0]  pos_y_o
);

  // wide enough for a coordinate plus step plus rectangle size
  localparam int AW    = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 3;
  localparam int CTR_W = SIZE_W + 1;

  logic do_load, do_div, do_move, do_recip, do_clamp, do_center, do_wrap, do_emit;

  assign do_load   = ctrl_i.en && (ctrl_i.op == OP_LOAD);
  assign do_div    = ctrl_i.en && (ctrl_i.op == OP_DIV);
  assign do_move   = ctrl_i.en && (ctrl_i.op == OP_MOVE);
  assign do_recip  = ctrl_i.en && (ctrl_i.op == OP_RECIP);
  assign do_clamp  = ctrl_i.en && (ctrl_i.op == OP_CLAMP);
  assign do_center = ctrl_i.en && (ctrl_i.op == OP_CENTER);
  assign do_wrap   = ctrl_i.en && (ctrl_i.op == OP_WRAP);
  assign do_emit   = ctrl_i.en && (ctrl_i.op == OP_EMIT);

  // config derived values
  logic [TICK_W-1:0]  tick;
  logic [PHASE_W-1:0] tick_ext, bounce_end, pause_end, center_end;
  logic [SKEW_W-1:0]  skew;

  assign tick       = (cfg_i.tick_ms < TICK_MIN) ? TICK_MIN : cfg_i.tick_ms;
  assign tick_ext   = {{(PHASE_W-TICK_W){1'b0}}, tick};
  assign skew       = (cfg_i.skew_divisor == '0) ? SKEW_W'(1) : cfg_i.skew_divisor;
  assign bounce_end = PHASE_W'(cfg_i.bounce_seconds) * MS_PER_S;
  assign pause_end  = bounce_end + PHASE_W'(cfg_i.pause_seconds) * MS_PER_S;
  assign center_end = bounce_end + CENTER_MS;

  // state
  logic [PHASE_W-1:0]    phase_q;
  logic [COORD_BITS-1:0] ball_x_q, ball_y_q;
  logic                  left_q, up_q;
  logic [SIZE_W-1:0]     top_q;
  logic                  out_valid_q;

  // per-item working registers
  logic [SIZE_W-1:0]       w_q, h_q;
  logic [PCT_W-1:0]        pct_q;
  logic signed [AW-1:0]    x_q, y_q;
  logic [PROD_W-1:0]       prod_q;
  logic [SIZE_W-1:0]       hop_q;
  logic [KIND_W-1:0]       res_kind_q, out_kind_q;
  logic signed [OUT_W-1:0] res_x_q, res_y_q, out_x_q, out_y_q;

  // skew division
  logic [STEP_W-1:0] dx_raw;
  logic              div_more;

  bsm_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (do_load),
    .step_i     (do_div),
    .dividend_i (cfg_i.step_pixels),
    .divisor_i  (skew),
    .quotient_o (dx_raw),
    .more_o     (div_more)
  );

  // candidate move
  logic signed [AW-1:0] bx, by, dx, dy, x_move, y_move;

  assign bx     = {{(AW-COORD_BITS){ball_x_q[COORD_BITS-1]}}, ball_x_q};
  assign by     = {{(AW-COORD_BITS){ball_y_q[COORD_BITS-1]}}, ball_y_q};
  assign dx     = {{(AW-STEP_W){1'b0}}, dx_raw};
  assign dy     = {{(AW-STEP_W){1'b0}}, cfg_i.step_pixels};
  assign x_move = left_q ? (bx - dx) : (bx + dx);
  assign y_move = up_q ? (by - dy) : (by + dy);

  // hop height product and reciprocal scaling
  logic [PCT_W-1:0]          pct_in;
  logic [PROD_W-1:0]         prod_d;
  logic [PROD_W+RECIP_W-1:0] hop_full;

  assign pct_in   = (random_percent_i > PCT_MAX) ? PCT_MAX : random_percent_i;
  assign prod_d   = {{PCT_W{1'b0}}, cfg_i.screen_height} * {{SCREEN_W{1'b0}}, pct_q};
  assign hop_full = {{RECIP_W{1'b0}}, prod_q} * {{PROD_W{1'b0}}, RECIP_M};

  // clamp at the edges
  logic signed [AW-1:0]  sw_ext, sh_ext, w_ext, h_ext, top_ext, x_fin, y_fin;
  logic signed [AW-1:0]  x_sx, y_sx;
  logic [COORD_BITS-1:0] x_wrap, y_wrap;
  logic                  left_d, up_d;
  logic [SIZE_W-1:0]     top_d;

  assign sw_ext  = {{(AW-SCREEN_W){1'b0}}, cfg_i.screen_width};
  assign sh_ext  = {{(AW-SCREEN_W){1'b0}}, cfg_i.screen_height};
  assign w_ext   = {{(AW-SIZE_W){1'b0}}, w_q};
  assign h_ext   = {{(AW-SIZE_W){1'b0}}, h_q};
  assign top_ext = {{(AW-SIZE_W){1'b0}}, top_q};

  always_comb begin
    x_fin  = x_q;
    left_d = left_q;
    if (x_q[AW-1]) begin
      x_fin  = '0;
      left_d = 1'b0;
    end else if (x_q + w_ext > sw_ext) begin
      x_fin  = sw_ext - w_ext;
      left_d = 1'b1;
    end

    y_fin = y_q;
    up_d  = up_q;
    top_d = top_q;
    if (y_q < top_ext) begin
      y_fin = top_ext;
      up_d  = 1'b0;
    end else if (y_q + h_ext > sh_ext) begin
      // floor bounce picks the next top limit
      top_d = cfg_i.random_hop ? hop_q : '0;
      y_fin = sh_ext - h_ext;
      up_d  = 1'b1;
    end
  end

  assign x_wrap = x_fin[COORD_BITS-1:0];
  assign y_wrap = y_fin[COORD_BITS-1:0];
  assign x_sx   = {{(AW-COORD_BITS){x_wrap[COORD_BITS-1]}}, x_wrap};
  assign y_sx   = {{(AW-COORD_BITS){y_wrap[COORD_BITS-1]}}, y_wrap};

  // centred position
  logic signed [CTR_W-1:0] cx, cy;
  logic                    in_window;

  assign cx = {2'b00, cfg_i.screen_width[SCREEN_W-1:1]} - {2'b00, w_q[SIZE_W-1:1]};
  assign cy = {2'b00, cfg_i.screen_height[SCREEN_W-1:1]} - {2'b00, h_q[SIZE_W-1:1]};
  assign in_window = (phase_q < center_end);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      ball_x_q    <= '0;
      ball_y_q    <= '0;
      left_q      <= 1'b0;
      up_q        <= 1'b0;
      top_q       <= SIZE_W'(INITIAL_TOP);
      out_valid_q <= 1'b0;
    end else begin
      if (do_load || do_center) begin
        phase_q <= phase_q + tick_ext;
      end else if (do_wrap && (phase_q >= pause_end)) begin
        phase_q <= '0;
      end
      if (do_clamp) begin
        ball_x_q <= x_wrap;
        ball_y_q <= y_wrap;
        left_q   <= left_d;
        up_q     <= up_d;
        top_q    <= top_d;
      end
      if (do_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      w_q   <= rect_width_i;
      h_q   <= rect_height_i;
      pct_q <= pct_in;
    end
    if (do_move) begin
      x_q    <= x_move;
      y_q    <= y_move;
      prod_q <= prod_d;
    end
    if (do_recip) begin
      hop_q <= hop_full[RECIP_K+SIZE_W-1:RECIP_K];
    end
    if (do_clamp) begin
      res_kind_q <= KIND_STEP;
      res_x_q    <= x_sx[OUT_W-1:0];
      res_y_q    <= y_sx[OUT_W-1:0];
    end else if (do_center) begin
      if (in_window) begin
        res_kind_q <= KIND_CENTER;
        res_x_q    <= {{(OUT_W-CTR_W){cx[CTR_W-1]}}, cx};
        res_y_q    <= {{(OUT_W-CTR_W){cy[CTR_W-1]}}, cy};
      end else begin
        res_kind_q <= KIND_NONE;
        res_x_q    <= '0;
        res_y_q    <= '0;
      end
    end
    if (do_emit) begin
      out_kind_q <= res_kind_q;
      out_x_q    <= res_x_q;
      out_y_q    <= res_y_q;
    end
  end

  assign status_o.in_valid    = in_valid_i;
  assign status_o.out_blocked = out_valid_q && out_stall_i;
  assign status_o.pause       = (phase_q >= bounce_end);
  assign status_o.div_more    = div_more;

  assign out_valid_o = out_valid_q;
  assign move_kind_o = out_kind_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;

endmodule

// ===== rtl/core/bouncing_sprite_motion_core.sv =====
// ---------------------------------------------------------------------------
// bouncing_sprite_motion_core
// timer-driven motion of a bouncing rectangle with a centred pause phase
// ---------------------------------------------------------------------------
// each input word is one timer tick and gives exactly one output word. the
// block takes one tick at a time: a tick in the bounce phase passes through
// the serial skew divider, which yields one quotient bit per cycle over the
// 10-bit step; a tick in the pause phase skips the divider. a finished word
// sits in the output register, so the next tick is taken while it waits;
// only when a second word is ready before the first has been taken does the
// sequencer wait at its emit step. control is a small microcode store
// (fetch, phase check, divide loop, move, hop scaling, clamp, centre, wrap,
// emit) driving a single datapath. configuration must be written only while
// no tick is in flight; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module bouncing_sprite_motion_core import bsm_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int INITIAL_TOP = INITIAL_TOP_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // register write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  // tick words
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [SIZE_W-1:0]       rect_width_i,
  input  logic [SIZE_W-1:0]       rect_height_i,
  input  logic [PCT_W-1:0]        random_percent_i,
  // result words
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [KIND_W-1:0]       move_kind_o,
  output logic signed [OUT_W-1:0] pos_x_o,
  output logic signed [OUT_W-1:0] pos_y_o
);

  // configuration registers, truncated to each register's width
  bsm_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_pixels    <= RST_STEP_PIXELS;
      cfg_q.skew_divisor   <= RST_SKEW_DIVISOR;
      cfg_q.screen_width   <= RST_SCREEN_WIDTH;
      cfg_q.screen_height  <= RST_SCREEN_HEIGHT;
      cfg_q.random_hop     <= RST_RANDOM_HOP;
      cfg_q.tick_ms        <= RST_TICK_MS;
      cfg_q.bounce_seconds <= RST_BOUNCE_SECONDS;
      cfg_q.pause_seconds  <= RST_PAUSE_SECONDS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_STEP_PIXELS:    cfg_q.step_pixels    <= cfg_data_i[STEP_W-1:0];
        REG_SKEW_DIVISOR:   cfg_q.skew_divisor   <= cfg_data_i[SKEW_W-1:0];
        REG_SCREEN_WIDTH:   cfg_q.screen_width   <= cfg_data_i[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT:  cfg_q.screen_height  <= cfg_data_i[SCREEN_W-1:0];
        REG_RANDOM_HOP:     cfg_q.random_hop     <= cfg_data_i[0];
        REG_TICK_MS:        cfg_q.tick_ms        <= cfg_data_i[TICK_W-1:0];
        REG_BOUNCE_SECONDS: cfg_q.bounce_seconds <= cfg_data_i[SEC_W-1:0];
        REG_PAUSE_SECONDS:  cfg_q.pause_seconds  <= cfg_data_i[SEC_W-1:0];
      endcase
    end
  end

  // sequencer to datapath
  bsm_ctrl_t   ctrl;
  bsm_status_t status;

  bsm_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  bsm_datapath #(
    .COORD_BITS  (COORD_BITS),
    .INITIAL_TOP (INITIAL_TOP)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .ctrl_i           (ctrl),
    .in_valid_i       (in_valid_i),
    .rect_width_i     (rect_width_i),
    .rect_height_i    (rect_height_i),
    .random_percent_i (random_percent_i),
    .out_stall_i      (out_stall_i),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .move_kind_o      (move_kind_o),
    .pos_x_o          (pos_x_o),
    .pos_y_o          (pos_y_o)
  );

  // a tick is taken only at the fetch step; stalled during reset as well
  assign in_stall_o = !ctrl.ready;

endmodule

// ===== rtl/core/bsm_checker.sv =====
// ---------------------------------------------------------------------------
// bsm_checker
// port-level checks of the bouncing sprite motion core, bound to the top
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bsm_checker import bsm_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [KIND_W-1:0]       move_kind_o,
  input logic signed [OUT_W-1:0] pos_x_o,
  input logic signed [OUT_W-1:0] pos_y_o
);

  // a waiting word holds
  `BSM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(move_kind_o) && $stable(pos_x_o) && $stable(pos_y_o))

  // a no-move word carries a zero position
  `BSM_ASSERT_IMPL(a_no_move_zero, out_valid_o && (move_kind_o == KIND_NONE), (pos_x_o == '0) && (pos_y_o == '0))

  // one tick at a time
  `BSM_ASSERT_NEXT(a_one_tick, in_valid_i && !in_stall_o, in_stall_o)

  // a result never appears in the cycle right after a tick is taken
  `BSM_ASSERT_NEXT(a_no_instant_word, in_valid_i && !in_stall_o, !$rose(out_valid_o))

endmodule

bind bouncing_sprite_motion_core bsm_checker u_bsm_checker (.*);
